FILE: src/bship_pkg.sv
package bship_pkg;

    localparam int WIDTH  = 1024;
    localparam int HEIGHT = 1024;

    localparam int FRAC_BITS = 28;

    localparam logic [31:0] COLOUR_MUL   = 32'd189979;
    localparam logic [63:0] ESCAPE_BOUND = 64'd1 << (2 * FRAC_BITS + 2);

    localparam logic [28:0] STEP_RESET   = 29'd1048576;
    localparam logic [31:0] ORIGIN_RESET = 32'hE000_0000;
    localparam logic [15:0] LIMIT_RESET  = 16'd50;

    typedef enum logic [2:0] {
        REG_PIXEL_STEP      = 3'd0,
        REG_ORIGIN_RE       = 3'd1,
        REG_ORIGIN_IM       = 3'd2,
        REG_ITERATION_LIMIT = 3'd3
    } t_reg_index;

    typedef struct packed {
        logic [31:0] op_a;
        logic [31:0] op_b;
    } t_mul_req;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -48'sh0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: src/burning_ship_escape_time.sv
// Burning Ship escape-time engine. Each pixel transaction (pixel_x, pixel_y) is mapped to
// c = (x*pixel_step + origin_re, y*pixel_step + origin_im) in signed Q4.28 and iterated
// with z = (zr^2 - zi^2 + cr, 2|zr*zi| + ci) until |z|^2 reaches 4.0 or the count reaches
// iteration_limit. One result carries pixel index, count and colour (count*189979, or 0
// at the limit). All products go through a single registered 32x32 multiplier: three
// products per iteration (zr^2, zi^2, zr*zi) plus an update state, with point mapping
// (x and y products) before the loop and the colour product after it.
// The block takes one pixel at a time; a finished result waits in an output register
// while the next pixel is accepted. Configuration is written through the cfg channel,
// which is always ready; index 0 pixel_step, 1 origin_re, 2 origin_im, 3 iteration_limit.
module burning_ship_escape_time (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // pixel_x [9:0], pixel_y [19:10], zero [23:20]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // pixel_index [19:0], escape_count [35:20],
                                     // pixel_colour [67:36], zero [71:68]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import bship_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP_X,
        S_MAP_Y,
        S_LOAD_CI,
        S_ITER_SR,
        S_ITER_SI,
        S_ITER_X,
        S_ITER_UPD,
        S_COLOUR,
        S_DONE
    } t_state;

    t_state r_state;

    logic [28:0]        r_step;
    logic signed [31:0] r_origin_re;
    logic signed [31:0] r_origin_im;
    logic [15:0]        r_limit;

    logic [9:0]         r_px;
    logic [9:0]         r_py;
    logic [15:0]        r_lim;
    logic [15:0]        r_count;
    logic signed [31:0] r_cr;
    logic signed [31:0] r_ci;
    logic signed [31:0] r_zr;
    logic signed [31:0] r_zi;
    logic [62:0]        r_sr;
    logic [62:0]        r_si;

    logic               r_out_valid;
    logic [19:0]        r_out_index;
    logic [15:0]        r_out_count;
    logic [31:0]        r_out_colour;

    t_mul_req           mul_req;
    logic [63:0]        prod;
    logic [31:0]        abs_zr;
    logic [31:0]        abs_zi;
    logic [63:0]        mag;
    logic               escape;
    logic signed [63:0] diff;
    logic signed [47:0] sum_re;
    logic signed [47:0] sum_im;
    logic signed [31:0] n_zr;
    logic signed [31:0] n_zi;
    logic signed [31:0] n_cr;
    logic signed [31:0] n_ci;
    logic               out_free;
    logic               s_accept;

    assign abs_zr = r_zr[31] ? 32'(-{r_zr[31], r_zr}) : 32'(r_zr);
    assign abs_zi = r_zi[31] ? 32'(-{r_zi[31], r_zi}) : 32'(r_zi);

    always_comb begin
        mul_req = '0;
        unique case (r_state)
            S_MAP_X: begin
                mul_req.op_a = 32'(r_px);
                mul_req.op_b = 32'(r_step);
            end
            S_MAP_Y: begin
                mul_req.op_a = 32'(r_py);
                mul_req.op_b = 32'(r_step);
            end
            S_ITER_SR: begin
                mul_req.op_a = abs_zr;
                mul_req.op_b = abs_zr;
            end
            S_ITER_SI: begin
                mul_req.op_a = abs_zi;
                mul_req.op_b = abs_zi;
            end
            S_ITER_X: begin
                mul_req.op_a = abs_zr;
                mul_req.op_b = abs_zi;
            end
            S_COLOUR, S_DONE: begin
                mul_req.op_a = 32'(r_count);
                mul_req.op_b = COLOUR_MUL;
            end
            default: mul_req = '0;
        endcase
    end

    bship_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    // escape test and z update
    assign mag    = 64'(r_sr) + prod;
    assign escape = (mag >= ESCAPE_BOUND) || (r_count >= r_lim);
    assign diff   = signed'({1'b0, r_sr}) - signed'({1'b0, r_si});
    assign sum_re = 48'(signed'(diff[63:FRAC_BITS])) + 48'(r_cr);
    assign sum_im = signed'({12'b0, prod[62:FRAC_BITS-1]}) + 48'(r_ci);
    assign n_zr   = sat32(sum_re);
    assign n_zi   = sat32(sum_im);

    // point mapping
    assign n_cr = sat32(signed'({9'b0, prod[38:0]}) + 48'(r_origin_re));
    assign n_ci = sat32(signed'({9'b0, prod[38:0]}) + 48'(r_origin_im));

    assign out_free = !r_out_valid || i_m_tready;
    assign s_accept = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= STEP_RESET;
            r_origin_re <= ORIGIN_RESET;
            r_origin_im <= ORIGIN_RESET;
            r_limit     <= LIMIT_RESET;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_PIXEL_STEP:      r_step      <= i_cfg_data[28:0];
                    REG_ORIGIN_RE:       r_origin_re <= i_cfg_data;
                    REG_ORIGIN_IM:       r_origin_im <= i_cfg_data;
                    REG_ITERATION_LIMIT: r_limit     <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_px    <= i_s_tdata[9:0];
                        r_py    <= i_s_tdata[19:10];
                        r_lim   <= r_limit;
                        r_state <= S_MAP_X;
                    end
                end
                S_MAP_X: begin
                    r_state <= S_MAP_Y;
                end
                S_MAP_Y: begin
                    r_cr    <= n_cr;
                    r_state <= S_LOAD_CI;
                end
                S_LOAD_CI: begin
                    r_ci    <= n_ci;
                    r_zr    <= '0;
                    r_zi    <= '0;
                    r_count <= '0;
                    r_state <= S_ITER_SR;
                end
                S_ITER_SR: begin
                    r_state <= S_ITER_SI;
                end
                S_ITER_SI: begin
                    r_sr    <= prod[62:0];
                    r_state <= S_ITER_X;
                end
                S_ITER_X: begin
                    r_si    <= prod[62:0];
                    r_state <= escape ? S_COLOUR : S_ITER_UPD;
                end
                S_ITER_UPD: begin
                    r_zr    <= n_zr;
                    r_zi    <= n_zi;
                    r_count <= r_count + 16'd1;
                    r_state <= S_ITER_SR;
                end
                S_COLOUR: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_index  <= 20'(r_px) + 20'(r_py) * 20'(WIDTH);
                        r_out_count  <= r_count;
                        r_out_colour <= (r_count == r_lim) ? 32'd0 : prod[31:0];
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {4'b0, r_out_colour, r_out_count, r_out_index};

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == S_MAP_X))
        else $error("accepted pixel did not start mapping");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER_SR || r_state == S_ITER_SI || r_state == S_ITER_X ||
         r_state == S_ITER_UPD) |-> (r_count <= r_lim))
        else $error("iteration count above limit");

    a_colour_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=>
        ((r_out_colour == 32'd0) || (r_out_count != r_lim)))
        else $error("colour not zero at iteration limit");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !out_free) |=> (r_state == S_DONE) && r_out_valid)
        else $error("result overwrote pending output");

endmodule

FILE: src/bship_mul.sv
module bship_mul (
    input  logic                 i_clk,
    input  bship_pkg::t_mul_req  i_req,
    output logic [63:0]          o_prod
);
    import bship_pkg::*;

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_req.op_a) * 64'(i_req.op_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: tb/burning_ship_escape_time_tb.sv
module burning_ship_escape_time_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bship_pkg::*;

    localparam logic [2:0]  REG_UNMAPPED_LO  = 3'd4;
    localparam logic [2:0]  REG_UNMAPPED_HI  = 3'd7;
    localparam int          Q_FRAC           = 28;
    localparam logic [63:0] RADIUS_SQ_LIMIT  = 64'd4 << (2 * Q_FRAC);
    localparam logic [31:0] COLOUR_FACTOR    = 32'd189979;
    localparam int          RANDOM_PIXELS    = 850;
    localparam int          HOLD_CYCLES      = 1500;
    localparam int          SETTLE_CYCLES    = 10;
    localparam int          DRAIN_CYCLES     = 40;
    localparam int          WATCHDOG_LIMIT   = 1000000;

    typedef struct {
        logic [19:0] index;
        logic [15:0] count;
        logic [31:0] colour;
    } pixel_result_t;

    class escape_time_scoreboard;
        logic [28:0]   pixel_step;
        int            origin_re;
        int            origin_im;
        logic [15:0]   iteration_limit;
        pixel_result_t expected_pixels[$];
        int            mismatch_count;

        function new();
            pixel_step      = 29'd1048576;
            origin_re       = -536870912;
            origin_im       = -536870912;
            iteration_limit = 16'd50;
            mismatch_count  = 0;
        endfunction

        function void write_register(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_PIXEL_STEP:      pixel_step      = data[28:0];
                REG_ORIGIN_RE:       origin_re       = data;
                REG_ORIGIN_IM:       origin_im       = data;
                REG_ITERATION_LIMIT: iteration_limit = data[15:0];
                default: ;
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
            if (v < -longint'(64'h8000_0000)) return -longint'(64'h8000_0000);
            return v;
        endfunction

        function pixel_result_t escape_time_of(logic [9:0] px, logic [9:0] py);
            pixel_result_t r;
            longint        cr;
            longint        ci;
            longint        zr;
            longint        zi;
            longint        nr;
            logic [63:0]   ar;
            logic [63:0]   ai;
            logic [63:0]   sr;
            logic [63:0]   si;
            logic [63:0]   ni;
            int unsigned   count;
            cr = clamp32(longint'(px) * longint'(pixel_step) + longint'(origin_re));
            ci = clamp32(longint'(py) * longint'(pixel_step) + longint'(origin_im));
            zr = 0;
            zi = 0;
            count = 0;
            while (1) begin
                ar = (zr < 0) ? 64'(-zr) : 64'(zr);
                ai = (zi < 0) ? 64'(-zi) : 64'(zi);
                sr = ar * ar;
                si = ai * ai;
                if (sr + si >= RADIUS_SQ_LIMIT || count >= iteration_limit) break;
                nr = ((longint'(sr) - longint'(si)) >>> Q_FRAC) + cr;
                ni = ((ar * ai) << 1) >> Q_FRAC;
                zr = clamp32(nr);
                zi = clamp32(longint'(ni) + ci);
                count++;
            end
            r.index  = 20'(int'(px) + int'(py) * WIDTH);
            r.count  = 16'(count);
            r.colour = (count == iteration_limit) ? 32'd0 : 32'(count) * COLOUR_FACTOR;
            return r;
        endfunction

        function void add_pixel(logic [9:0] px, logic [9:0] py);
            expected_pixels.push_back(escape_time_of(px, py));
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void check_result(logic [71:0] data);
            pixel_result_t exp_r;
            if (expected_pixels.size() == 0) begin
                $error("unexpected result transaction %h", data);
                mismatch_count++;
                return;
            end
            exp_r = expected_pixels.pop_front();
            if (data[19:0] !== exp_r.index) begin
                $error("pixel_index expected %0d actual %0d", exp_r.index, data[19:0]);
                mismatch_count++;
            end
            if (data[35:20] !== exp_r.count) begin
                $error("escape_count expected %0d actual %0d", exp_r.count, data[35:20]);
                mismatch_count++;
            end
            if (data[67:36] !== exp_r.colour) begin
                $error("pixel_colour expected %0d actual %0d", exp_r.colour, data[67:36]);
                mismatch_count++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    escape_time_scoreboard board;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned stalled_cycles = 0;

    burning_ship_escape_time dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic apply_view(input logic [31:0] step, input logic [31:0] re,
                              input logic [31:0] im, input logic [31:0] limit);
        write_register(REG_ORIGIN_IM, im);
        write_register(REG_PIXEL_STEP, step);
        write_register(REG_ITERATION_LIMIT, limit);
        write_register(REG_ORIGIN_RE, re);
    endtask

    task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
        int unsigned gap;
        i_s_tdata  = {4'b0, py, px};
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        gap = tx_steady ? 0 : idle_len();
        @(negedge i_clk);
        if (gap != 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // transaction monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) board.write_register(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && o_s_tready) board.add_pixel(i_s_tdata[9:0], i_s_tdata[19:10]);
            if (o_m_tvalid && i_m_tready) board.check_result(o_m_tdata);
            if ((i_cfg_valid && o_cfg_ready) || (i_s_tvalid && o_s_tready)
                    || (o_m_tvalid && i_m_tready)) begin
                stalled_cycles = 0;
            end else begin
                stalled_cycles++;
            end
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
                i_m_tready = 1'b0;
                repeat (idle_len() + 1) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
        end
    end

    initial begin
        int          sent;
        int          phase;
        int          n;
        int unsigned r;
        logic [31:0] step;
        logic [31:0] re;
        logic [31:0] im;
        logic [31:0] limit;
        logic [9:0]  px;
        logic [9:0]  py;

        board = new();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset view: corners, center of plane, alternating bits
        tx_steady = 1'b1;
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
        tx_steady = 1'b0;
        send_pixel(10'd512, 10'd512);
        send_pixel(10'h155, 10'h2AA);
        send_pixel(10'h2AA, 10'h155);
        wait_drained();

        // unmapped indexes ignored, zero step, limit of one
        write_register(REG_UNMAPPED_LO, $urandom());
        write_register(REG_UNMAPPED_HI, $urandom());
        send_pixel(10'd3, 10'd7);
        wait_drained();
        apply_view(32'd0, 32'hE400_0000, 32'hFF80_0000, 32'd1);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd5, 10'd9);
        wait_drained();

        // unit step (1.0) with saturating origins, zero limit then short limit
        apply_view(32'd268435456, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd0);
        wait_drained();
        write_register(REG_ITERATION_LIMIT, 32'd3);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1, 10'd1);
        wait_drained();

        // largest limit: one point that never escapes, then fast escapes
        apply_view(32'd0, 32'd0, 32'd0, 32'd65535);
        send_pixel(10'd200, 10'd300);
        wait_drained();
        apply_view(32'd1048576, 32'hE000_0000, 32'hE000_0000, 32'hFFFF_FFFF);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd100, 10'd900);
        wait_drained();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS) begin
            wait_drained();
            r = $urandom_range(0, 99);
            if (r < 70) step = $urandom_range(1 << 14, 1 << 21);
            else if (r < 85) step = $urandom_range(1, 268435456);
            else step = $urandom();
            re = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 32'h3000_0000) - 32'h2000_0000
                                             : $urandom();
            im = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 32'h3000_0000) - 32'h2000_0000
                                             : $urandom();
            r = $urandom_range(0, 99);
            if (r < 80) limit = $urandom_range(1, 64);
            else if (r < 95) limit = $urandom_range(65, 300);
            else limit = ($urandom() & 32'hFFFF_0000) | $urandom_range(0, 40);
            apply_view(step, re, im, limit);
            if ($urandom_range(0, 7) == 0)
                write_register(3'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)), $urandom());
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if (phase % 6 == 1) hold_request = 1'b1;
            n = $urandom_range(20, 60);
            repeat (n) begin
                px = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 10'd1023 : 10'd0)
                                                 : 10'($urandom_range(0, 1023));
                py = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 10'd1023 : 10'd0)
                                                 : 10'($urandom_range(0, 1023));
                send_pixel(px, py);
            end
            sent += n;
            phase++;
        end

        i_s_tvalid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (board.mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
